>>> design/set_assoc_cache_lru_dirty_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag directory
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_DIRTY_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_DIRTY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Constants, codes and the sequencer state type of the cache tag directory.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Default sizes of the directory.
  localparam int MAX_SET_BITS_DEF = 10;
  localparam int WAYS_DEF         = 8;

  // Field widths.
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int REQ_W      = 2;
  localparam int TOTAL_W    = 32;
  localparam int WB_W       = 48;
  localparam int NOW_W      = 46;
  localparam int SET_CFG_W  = 4;
  localparam int BLK_CFG_W  = 6;
  localparam int WAYS_CFG_W = 4;

  // Largest block size exponent that takes effect.
  localparam int MAX_BLOCK_BITS = 32;

  // Port widths.
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_FIELD_W = 2 + 1 + 1 + 1 + 3 * TOTAL_W + WB_W + NOW_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

  // Access kinds; the unused code behaves as a load.
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } state_t;

endpackage

>>> design/set_assoc_cache_lru_dirty.sv
`timescale 1ns / 1ps
// An accepted access passes through the SPLIT, READ, SCAN, UPDATE and RESULT states; the
// scan probes N ways (way of the hit plus one, or the ways in use on a miss).
// A new access is taken only once the last one is through; the tag compare unit probes one way per cycle.
// Reset: synchronous, active low. Afterwards a clearing pass writes every set row of the
// directory memory before the first access is accepted.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_dirty
// Tag directory of a set-associative write-back cache with LRU replacement and
// dirty tracking, with running hit, miss, eviction and write-back totals.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_dirty #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = sacl_pkg::WAYS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sacl_pkg::IN_TDATA_W-1:0]    in_tdata,   // [63:0] address
  input  logic [sacl_pkg::IN_TUSER_W-1:0]    in_tuser,   // [1:0] req_type
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] hits_added, [2] missed, [3] evicted, [4] dirty_evicted,
  // [36:5] total_hits, [68:37] total_misses, [100:69] total_evictions,
  // [148:101] dirty_evicted_bytes, [194:149] dirty_bytes_now, [199:195] zero
  output logic [sacl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration write port.
  input  logic                               cfg_wr_en,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sacl_pkg::*;

  localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROWS      = 1 << SET_IDX_W;
  localparam int WIDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W     = WIDX_W;
  localparam int USED_W    = $clog2(WAYS + 1);
  localparam int LINES     = ROWS * WAYS;
  localparam int CNT_W     = $clog2(LINES + 1);
  localparam int SB_W      = 7;

  localparam logic [AGE_W-1:0]   AGE_MAX  = AGE_W'(WAYS - 1);
  localparam logic [TOTAL_W-1:0] TOT_MAX  = {TOTAL_W{1'b1}};
  localparam logic [WB_W-1:0]    WB_MAX   = {WB_W{1'b1}};
  localparam logic [63:0]        NOW_MAX  = 64'((64'd1 << NOW_W) - 64'd1);

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  // Directory memory: one row per set, all ways side by side.
  row_t line_mem [ROWS];

  state_t st_r, st_nxt;

  // Configuration registers.
  logic [SET_CFG_W-1:0]  set_bits_r;
  logic [BLK_CFG_W-1:0]  block_bits_r;
  logic [WAYS_CFG_W-1:0] ways_used_r;

  // Access in flight.
  logic [REQ_W-1:0]     req_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [TAG_W-1:0]     tag_r;
  logic [SET_IDX_W-1:0] set_r;
  row_t                 rd_row_r;

  // Scan state.
  logic [USED_W-1:0] scan_cnt_r;
  logic              hit_r;
  logic [WIDX_W-1:0] hit_way_r;
  logic              have_free_r;
  logic [WIDX_W-1:0] free_way_r;
  logic [WIDX_W-1:0] vict_way_r;
  logic [AGE_W-1:0]  vict_age_r;

  // Per-access flags.
  logic [1:0] hits_add_r;
  logic       evicted_r;
  logic       dirty_ev_r;

  // Running totals.
  logic [TOTAL_W-1:0] hit_tot_r;
  logic [TOTAL_W-1:0] miss_tot_r;
  logic [TOTAL_W-1:0] evict_tot_r;
  logic [WB_W-1:0]    wb_bytes_r;
  logic [CNT_W-1:0]   dirty_cnt_r;

  logic [SET_IDX_W-1:0] clr_cnt_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Effective configuration after clamping.
  logic [4:0]        s_eff;
  logic [5:0]        b_eff;
  logic [4:0]        ways_ext;
  logic [4:0]        used5;
  logic [USED_W-1:0] used_eff;

  always_comb begin
    s_eff    = ({1'b0, set_bits_r} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                       : {1'b0, set_bits_r};
    b_eff    = (block_bits_r > 6'(MAX_BLOCK_BITS)) ? 6'(MAX_BLOCK_BITS) : block_bits_r;
    ways_ext = {1'b0, ways_used_r};
    if (ways_ext == 5'd0) begin
      used5 = 5'd1;
    end else if (ways_ext > 5'(WAYS)) begin
      used5 = 5'(WAYS);
    end else begin
      used5 = ways_ext;
    end
    used_eff = USED_W'(used5);
  end

  // Access kind decode.
  logic writes;
  logic modify;
  assign modify = (req_r == REQ_MODIFY);
  assign writes = (req_r == REQ_STORE) || (req_r == REQ_MODIFY);

  // Address split into tag and set index.
  logic [SB_W-1:0]   sb_sum;
  logic [ADDR_W-1:0] set_full;
  assign sb_sum   = SB_W'(s_eff) + SB_W'(b_eff);
  assign set_full = (addr_r >> b_eff) & ~({ADDR_W{1'b1}} << s_eff);

  // Shared compare unit: one way of the row per cycle.
  line_t             scan_ln;
  logic [WIDX_W-1:0] scan_idx;
  logic              scan_hit;
  logic              scan_last;
  assign scan_idx  = scan_cnt_r[WIDX_W-1:0];
  assign scan_ln   = rd_row_r[scan_idx];
  assign scan_hit  = scan_ln.valid && (scan_ln.tag == tag_r);
  assign scan_last = (scan_cnt_r == used_eff - USED_W'(1));

  // Row update: LRU ranks, fill or replacement, dirty mark.
  logic [WIDX_W-1:0] sel_way;
  line_t             old_ln;
  logic              do_fill;
  logic              do_evict;
  logic              old_dirty_kept;
  logic              dirty_ev;
  row_t              new_row;

  always_comb begin
    sel_way  = hit_r ? hit_way_r : (have_free_r ? free_way_r : vict_way_r);
    old_ln   = rd_row_r[sel_way];
    do_fill  = !hit_r && have_free_r;
    do_evict = !hit_r && !have_free_r;
    dirty_ev = do_evict && old_ln.dirty;
    old_dirty_kept = hit_r && old_ln.dirty;
    new_row  = rd_row_r;
    for (int i = 0; i < WAYS; i++) begin
      if ((USED_W'(i) < used_eff) && (WIDX_W'(i) != sel_way) && rd_row_r[i].valid &&
          (do_fill || (rd_row_r[i].age < old_ln.age)) && (rd_row_r[i].age < AGE_MAX)) begin
        new_row[i].age = rd_row_r[i].age + AGE_W'(1);
      end
    end
    new_row[sel_way].valid = 1'b1;
    new_row[sel_way].age   = '0;
    new_row[sel_way].tag   = hit_r ? old_ln.tag : tag_r;
    new_row[sel_way].dirty = old_dirty_kept || writes;
  end

  // Saturating totals for the update cycle.
  logic [1:0]         hits_now;
  logic [TOTAL_W:0]   hit_sum;
  logic [TOTAL_W:0]   miss_sum;
  logic [TOTAL_W:0]   evict_sum;
  logic [WB_W-1:0]    block_size;
  logic [WB_W:0]      wb_sum;
  logic [CNT_W-1:0]   dirty_cnt_dec;
  logic [CNT_W-1:0]   dirty_cnt_upd;

  always_comb begin
    if (hit_r) begin
      hits_now = modify ? 2'd2 : 2'd1;
    end else begin
      hits_now = modify ? 2'd1 : 2'd0;
    end
    hit_sum    = {1'b0, hit_tot_r} + (TOTAL_W + 1)'(hits_now);
    miss_sum   = {1'b0, miss_tot_r} + (TOTAL_W + 1)'(1);
    evict_sum  = {1'b0, evict_tot_r} + (TOTAL_W + 1)'(1);
    block_size = WB_W'(1) << b_eff;
    wb_sum     = {1'b0, wb_bytes_r} + {1'b0, block_size};
    dirty_cnt_dec = (dirty_ev && (dirty_cnt_r != '0)) ? dirty_cnt_r - CNT_W'(1) : dirty_cnt_r;
    dirty_cnt_upd = (writes && !old_dirty_kept) ? dirty_cnt_dec + CNT_W'(1) : dirty_cnt_dec;
  end

  // Dirty bytes held, saturated to the field width.
  logic [63:0]      bytes_shift;
  logic [NOW_W-1:0] bytes_now;
  assign bytes_shift = 64'(dirty_cnt_r) << b_eff;
  assign bytes_now   = (bytes_shift > NOW_MAX) ? NOW_MAX[NOW_W-1:0] : bytes_shift[NOW_W-1:0];

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:  if (clr_cnt_r == {SET_IDX_W{1'b1}}) st_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) st_nxt = ST_SPLIT;
      ST_SPLIT:  st_nxt = ST_READ;
      ST_READ:   st_nxt = ST_SCAN;
      ST_SCAN:   if (scan_hit || scan_last) st_nxt = ST_UPDATE;
      ST_UPDATE: st_nxt = ST_RESULT;
      ST_RESULT: if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_CLEAR;
    endcase
  end

  // Sequencer outputs.
  logic mem_we;
  row_t mem_wdata;
  logic [SET_IDX_W-1:0] mem_waddr;
  logic out_load;

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = new_row;
    mem_waddr = set_r;
    out_load  = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_waddr = clr_cnt_r;
      end
      ST_IDLE:   in_tready = 1'b1;
      ST_UPDATE: mem_we = 1'b1;
      ST_RESULT: out_load = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // State register and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLEAR;
      clr_cnt_r    <= '0;
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_used_r  <= WAYS_CFG_W'(1);
      out_tvalid_r <= 1'b0;
      hit_tot_r    <= '0;
      miss_tot_r   <= '0;
      evict_tot_r  <= '0;
      wb_bytes_r   <= '0;
      dirty_cnt_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_IDX_W'(1);
      end
      // Configuration writes.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SET_CFG_W-1:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BLK_CFG_W-1:0];
          CFG_WAYS_USED:  ways_used_r  <= cfg_wdata[WAYS_CFG_W-1:0];
          default: begin
            set_bits_r <= set_bits_r;
          end
        endcase
      end
      // Totals move once per access.
      if (st_r == ST_UPDATE) begin
        hit_tot_r <= hit_sum[TOTAL_W] ? TOT_MAX : hit_sum[TOTAL_W-1:0];
        if (!hit_r) begin
          miss_tot_r <= miss_sum[TOTAL_W] ? TOT_MAX : miss_sum[TOTAL_W-1:0];
        end
        if (do_evict) begin
          evict_tot_r <= evict_sum[TOTAL_W] ? TOT_MAX : evict_sum[TOTAL_W-1:0];
        end
        if (dirty_ev) begin
          wb_bytes_r <= wb_sum[WB_W] ? WB_MAX : wb_sum[WB_W-1:0];
        end
        dirty_cnt_r <= dirty_cnt_upd;
      end
      // Output register valid.
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers of the access in flight.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r  <= in_tuser;
      addr_r <= in_tdata;
    end
    if (st_r == ST_SPLIT) begin
      tag_r <= addr_r >> sb_sum;
      set_r <= set_full[SET_IDX_W-1:0];
    end
    if (st_r == ST_READ) begin
      scan_cnt_r  <= '0;
      hit_r       <= 1'b0;
      have_free_r <= 1'b0;
    end
    if (st_r == ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + USED_W'(1);
      if (scan_hit) begin
        hit_r     <= 1'b1;
        hit_way_r <= scan_idx;
      end
      if (!scan_ln.valid && !have_free_r) begin
        have_free_r <= 1'b1;
        free_way_r  <= scan_idx;
      end
      if ((scan_cnt_r == '0) || (scan_ln.age > vict_age_r)) begin
        vict_way_r <= scan_idx;
        vict_age_r <= scan_ln.age;
      end
    end
    if (st_r == ST_UPDATE) begin
      hits_add_r <= hits_now;
      evicted_r  <= do_evict;
      dirty_ev_r <= dirty_ev;
    end
    if (out_load) begin
      out_tdata_r <= {(OUT_TDATA_W - OUT_FIELD_W)'(0), bytes_now, wb_bytes_r, evict_tot_r,
                      miss_tot_r, hit_tot_r, dirty_ev_r, evicted_r, !hit_r, hits_add_r};
    end
  end

  // Directory memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (st_r == ST_READ) begin
      rd_row_r <= line_mem[set_r];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks on the directory logic.
  `include "set_assoc_cache_lru_dirty_macros.svh"

  `SACL_ASSERT_SAME(a_dirty_cnt_bound, 1'b1, dirty_cnt_r <= CNT_W'(LINES), "dirty count above line count")
  `SACL_ASSERT_SAME(a_evict_flags, out_tvalid && out_tdata[4], out_tdata[3] && out_tdata[2], "dirty eviction without a miss and an eviction")
  `SACL_ASSERT_NEXT(a_miss_counted, st_r == ST_UPDATE && !hit_r, miss_tot_r != $past(miss_tot_r) || miss_tot_r == TOT_MAX, "miss not counted")
  `SACL_ASSERT_SAME(a_no_accept_busy, st_r != ST_IDLE, !in_tready, "input taken while an access is in flight")

endmodule
